[design/three_wire_serial_rtc_master_defines.svh]
// Assertion macros for the three-wire serial master.
`ifndef THREE_WIRE_SERIAL_RTC_MASTER_DEFINES_SVH
`define THREE_WIRE_SERIAL_RTC_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define TWS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("three_wire_serial_rtc_master: assertion failed");
// checked at every edge, reset included
`define TWS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("three_wire_serial_rtc_master: assertion failed");
`else
`define TWS_ASSERT(lbl, prop)
`define TWS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[design/tws_pkg.sv]
package tws_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_SEND_LOW  = 5'b00010,
		PH_SEND_HIGH = 5'b00100,
		PH_RECV_LOW  = 5'b01000,
		PH_RECV_HIGH = 5'b10000
	} phase_t;

	localparam logic [7:0] HALF_PERIOD_RESET = 8'd20;
	localparam logic [7:0] ADDR_READ_BIT     = 8'h01;
	localparam logic [7:0] ADDR_WRITE_MASK   = 8'hFE;
	localparam logic [3:0] LAST_BIT_BYTE     = 4'd7;
	localparam logic [3:0] LAST_BIT_WORD     = 4'd15;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       dat_in;
	} item_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       dat_out;
		logic       dat_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic busy;
		logic delay_nonzero;
	} status_t;

endpackage

[design/tws_core.sv]
module tws_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [7:0]       cfg_wdata,
	input  logic             fire,
	input  tws_pkg::item_t   item,
	output tws_pkg::result_t res,
	output tws_pkg::status_t status
);
	import tws_pkg::*;

	logic [7:0]  half_period_q;
	phase_t      phase_q, phase_n;
	logic [3:0]  bit_q, bit_n;
	logic [15:0] send_q, send_n;
	logic [7:0]  delay_q, delay_n;
	logic [7:0]  rx_q, rx_n;
	logic        reading_q, reading_n;
	logic        busy, is_req, done, rej, sending, high, act;
	logic [7:0]  half;
	logic [3:0]  last;

	always_comb begin
		phase_n   = phase_q;
		bit_n     = bit_q;
		send_n    = send_q;
		delay_n   = delay_q;
		rx_n      = rx_q;
		reading_n = reading_q;
		done      = 1'b0;
		rej       = 1'b0;
		half      = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
		busy      = (phase_q == PH_SEND_LOW) || (phase_q == PH_SEND_HIGH) ||
			(phase_q == PH_RECV_LOW) || (phase_q == PH_RECV_HIGH);
		is_req    = (item.req_type == REQ_WRITE) || (item.req_type == REQ_READ);
		last      = reading_q ? LAST_BIT_BYTE : LAST_BIT_WORD;

		if (!busy) begin
			phase_n = PH_IDLE;
			if (is_req) begin
				reading_n = (item.req_type == REQ_READ);
				if (item.req_type == REQ_READ) begin
					send_n = {8'h00, item.reg_addr | ADDR_READ_BIT};
					rx_n   = 8'h00;
				end else begin
					send_n = {item.write_data, item.reg_addr & ADDR_WRITE_MASK};
				end
				bit_n   = 4'd0;
				phase_n = PH_SEND_LOW;
				delay_n = half;
			end
		end else begin
			rej = is_req;
			if (delay_q > 8'd1) begin
				delay_n = delay_q - 8'd1;
			end else begin
				case (phase_q)
					PH_SEND_LOW: begin
						phase_n = PH_SEND_HIGH;
						delay_n = half;
					end
					PH_SEND_HIGH: begin
						send_n = {1'b0, send_q[15:1]};
						if (bit_q >= last) begin
							bit_n = 4'd0;
							if (reading_q) begin
								phase_n = PH_RECV_LOW;
								delay_n = half;
							end else begin
								phase_n = PH_IDLE;
								delay_n = 8'd0;
								done    = 1'b1;
							end
						end else begin
							bit_n   = bit_q + 4'd1;
							phase_n = PH_SEND_LOW;
							delay_n = half;
						end
					end
					PH_RECV_LOW: begin
						// sample on the tick that raises the clock
						rx_n[bit_q[2:0]] = item.dat_in;
						phase_n = PH_RECV_HIGH;
						delay_n = half;
					end
					PH_RECV_HIGH: begin
						if (bit_q >= LAST_BIT_BYTE) begin
							bit_n   = 4'd0;
							phase_n = PH_IDLE;
							delay_n = 8'd0;
							done    = 1'b1;
						end else begin
							bit_n   = bit_q + 4'd1;
							phase_n = PH_RECV_LOW;
							delay_n = half;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end

		act     = (phase_n != PH_IDLE);
		sending = (phase_n == PH_SEND_LOW) || (phase_n == PH_SEND_HIGH);
		high    = (phase_n == PH_SEND_HIGH) || (phase_n == PH_RECV_HIGH);

		res.chip_enable  = act;
		res.serial_clock = high;
		res.dat_out      = sending & send_n[0];
		res.dat_drive    = sending;
		res.busy_res     = act;
		res.done_res     = done;
		res.read_data    = rx_n;
		res.rejected     = rej;

		status.busy          = busy;
		status.delay_nonzero = (delay_q != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_wen) begin
			half_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= 4'd0;
			send_q    <= 16'h0000;
			delay_q   <= 8'd0;
			rx_q      <= 8'h00;
			reading_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_n;
			bit_q     <= bit_n;
			send_q    <= send_n;
			delay_q   <= delay_n;
			rx_q      <= rx_n;
			reading_q <= reading_n;
		end
	end

endmodule

[design/three_wire_serial_rtc_master.sv]
// Three-wire (chip enable, serial clock, bidirectional data) master for a
// real-time-clock chip, LSB first. Every input transfer is one timing tick and
// yields exactly one result transfer holding the line levels after that tick.
// A write request sends the address (bit 0 cleared) then the data byte; a read
// request sends the address (bit 0 set) then clocks in one byte, sampling
// dat_in on the tick that raises the clock. Each clock half lasts half_period
// ticks (0 acts as 1). Requests while busy are ignored and flagged. Rate: one
// tick per clock cycle sustained while the receiver keeps out_ready high; a
// result is offered once its tick has passed through the input register and
// the single-pass state update has landed in the result register. Write
// half_period only while idle.
`include "three_wire_serial_rtc_master_defines.svh"

module three_wire_serial_rtc_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       dat_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       chip_enable,
	output logic       serial_clock,
	output logic       dat_out,
	output logic       dat_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       rejected
);
	import tws_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_w;
	status_t status;
	logic    advance, fire, in_ready_w;

	assign advance    = !out_valid_q || out_ready;
	assign in_ready_w = !valid_s1 || advance;
	assign fire       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready_w) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready_w) begin
			item_s1 <= '{req_type: req_type, reg_addr: reg_addr,
				write_data: write_data, dat_in: dat_in};
		end
	end

	tws_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res_w),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_w;
		end
	end

	assign in_ready     = in_ready_w;
	assign out_valid    = out_valid_q;
	assign chip_enable  = res_q.chip_enable;
	assign serial_clock = res_q.serial_clock;
	assign dat_out      = res_q.dat_out;
	assign dat_drive    = res_q.dat_drive;
	assign busy_res     = res_q.busy_res;
	assign done_res     = res_q.done_res;
	assign read_data    = res_q.read_data;
	assign rejected     = res_q.rejected;

	// a live clock half always has ticks left to count
	`TWS_ASSERT(a_delay_live, status.busy |-> status.delay_nonzero)
	`TWS_ASSERT(a_fire_fills, fire |=> out_valid_q)
	`TWS_ASSERT(a_done_idle, out_valid_q && res_q.done_res |-> !res_q.busy_res)
	`TWS_ASSERT_ALWAYS(a_accept_open, !out_valid_q |-> in_ready_w)

endmodule

[tb/three_wire_serial_rtc_master_tb.sv]
`timescale 1ns / 1ps

module three_wire_serial_rtc_master_tb;
	import tws_pkg::*;

	// request code the block treats as a plain tick
	localparam logic [1:0] REQ_SPARE = 2'd3;

	localparam result_t LINES_IDLE = '0;
	localparam result_t WRITE_START = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

	typedef struct packed {
		logic       is_cfg;
		logic [7:0] cfg_val;
		item_t      it;
		logic       typed;
		result_t    want;
	} row_t;

	typedef struct packed {
		logic [7:0] half;
		int         send_pct;
		int         recv_pct;
		int         count;
		bit         hold;
	} phase_plan_t;

	localparam row_t PLAN [20] = '{
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b0}, 1'b1, LINES_IDLE},
		'{1'b0, 8'd0, '{REQ_SPARE, 8'hFF, 8'hFF, 1'b1}, 1'b1, LINES_IDLE},
		'{1'b1, 8'd0, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_WRITE, 8'hFF, 8'hFF, 1'b1}, 1'b1, WRITE_START},
		'{1'b0, 8'd0, '{REQ_READ, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_WRITE, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_SPARE, 8'h5A, 8'hA5, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b1, 8'd3, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_READ, 8'h01, 8'h80, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b1, 8'd255, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b1, 8'd1, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, '{REQ_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, '0}
	};

	localparam phase_plan_t PHASES [8] = '{
		'{8'd20,  0,  0,  80, 1'b0},
		'{8'd1,   0,  0, 120, 1'b0},
		'{8'd0,  77,  0, 100, 1'b0},
		'{8'd2,   0, 77, 100, 1'b0},
		'{8'd1,  10, 10, 100, 1'b0},
		'{8'd1,   0,  0,  80, 1'b1},
		'{8'd255, 0,  0, 150, 1'b0},
		'{8'd3,  10, 10,  60, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wen = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = 2'd0;
	logic [7:0] reg_addr = 8'd0;
	logic [7:0] write_data = 8'd0;
	logic       dat_in = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       chip_enable;
	logic       serial_clock;
	logic       dat_out;
	logic       dat_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       rejected;

	// predictor state
	logic [7:0]  half_q = HALF_PERIOD_RESET;
	phase_t      ph = PH_IDLE;
	logic [3:0]  bit_idx = '0;
	logic [15:0] tx_shift = '0;
	logic [7:0]  delay = '0;
	logic [7:0]  rx_shift = '0;
	logic        rd_mode = 1'b0;

	result_t lines_due [$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      holds_asked = 0;
	int      holds_seen = 0;
	int      hold_left = 0;

	three_wire_serial_rtc_master DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.reg_addr    (reg_addr),
		.write_data  (write_data),
		.dat_in      (dat_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chip_enable (chip_enable),
		.serial_clock(serial_clock),
		.dat_out     (dat_out),
		.dat_drive   (dat_drive),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_data   (read_data),
		.rejected    (rejected)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("** three_wire_serial_rtc_master: FAILED **");
		$finish;
	end

	function automatic void enter_half(phase_t nxt);
		ph = nxt;
		delay = (half_q == 8'd0) ? 8'd1 : half_q;
	endfunction

	// one tick of the serial master; returns the line levels after it
	function automatic result_t advance_rtc(item_t it);
		result_t r;
		logic    is_req;
		logic    fin;
		logic    rej;
		logic    snd;
		is_req = (it.req_type == REQ_WRITE) || (it.req_type == REQ_READ);
		fin = 1'b0;
		rej = 1'b0;
		if (ph == PH_IDLE) begin
			if (is_req) begin
				rd_mode = (it.req_type == REQ_READ);
				if (rd_mode) begin
					tx_shift = {8'h00, it.reg_addr | ADDR_READ_BIT};
					rx_shift = '0;
				end else begin
					tx_shift = {it.write_data, it.reg_addr & ADDR_WRITE_MASK};
				end
				bit_idx = '0;
				enter_half(PH_SEND_LOW);
			end
		end else begin
			rej = is_req;
			if (delay > 8'd1) begin
				delay = delay - 8'd1;
			end else begin
				case (ph)
					PH_SEND_LOW: enter_half(PH_SEND_HIGH);
					PH_SEND_HIGH: begin
						tx_shift = tx_shift >> 1;
						if (bit_idx >= (rd_mode ? LAST_BIT_BYTE : LAST_BIT_WORD)) begin
							bit_idx = '0;
							if (rd_mode) begin
								enter_half(PH_RECV_LOW);
							end else begin
								ph = PH_IDLE;
								delay = '0;
								fin = 1'b1;
							end
						end else begin
							bit_idx = bit_idx + 4'd1;
							enter_half(PH_SEND_LOW);
						end
					end
					PH_RECV_LOW: begin
						// pin sampled on the tick that raises the clock
						rx_shift[bit_idx[2:0]] = it.dat_in;
						enter_half(PH_RECV_HIGH);
					end
					default: begin
						if (bit_idx >= LAST_BIT_BYTE) begin
							bit_idx = '0;
							ph = PH_IDLE;
							delay = '0;
							fin = 1'b1;
						end else begin
							bit_idx = bit_idx + 4'd1;
							enter_half(PH_RECV_LOW);
						end
					end
				endcase
			end
		end
		snd = (ph == PH_SEND_LOW) || (ph == PH_SEND_HIGH);
		r.chip_enable = (ph != PH_IDLE);
		r.serial_clock = (ph == PH_SEND_HIGH) || (ph == PH_RECV_HIGH);
		r.dat_out = snd & tx_shift[0];
		r.dat_drive = snd;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		r.read_data = rx_shift;
		r.rejected = rej;
		return r;
	endfunction

	function automatic item_t draw_tick();
		item_t it;
		int    roll;
		roll = $urandom_range(0, 99);
		if (roll < 84)
			it.req_type = REQ_TICK;
		else if (roll < 91)
			it.req_type = REQ_WRITE;
		else if (roll < 98)
			it.req_type = REQ_READ;
		else
			it.req_type = REQ_SPARE;
		it.reg_addr = 8'($urandom);
		it.write_data = 8'($urandom);
		it.dat_in = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic offer_tick(item_t it, logic typed, result_t want);
		int      gap;
		result_t pred;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req_type;
		reg_addr <= it.reg_addr;
		write_data <= it.write_data;
		dat_in <= it.dat_in;
		do @(posedge clk); while (!in_ready);
		pred = advance_rtc(it);
		lines_due.push_back(typed ? want : pred);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (lines_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_half_period(logic [7:0] val);
		settle();
		cfg_wen <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		half_q = val;
	endtask

	task automatic compare_field(string nm, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, nm, want_v, got_v);
		end
	endtask

	// receiver: random back-pressure plus an occasional long hold-off
	always @(posedge clk) begin
		if (holds_seen != holds_asked) begin
			holds_seen = holds_asked;
			hold_left = 250;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{chip_enable, serial_clock, dat_out, dat_drive, busy_res, done_res,
				read_data, rejected};
			if (lines_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transfer, expected none, got %0h", $time, got);
			end else begin
				want = lines_due.pop_front();
				compare_field("chip_enable", 8'(want.chip_enable), 8'(got.chip_enable));
				compare_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
				compare_field("dat_out", 8'(want.dat_out), 8'(got.dat_out));
				compare_field("dat_drive", 8'(want.dat_drive), 8'(got.dat_drive));
				compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
				compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
				compare_field("read_data", want.read_data, got.read_data);
				compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
			end
		end
	end

	initial begin : stimulus
		item_t it;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].is_cfg)
				set_half_period(PLAN[i].cfg_val);
			else
				offer_tick(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
		end

		foreach (PHASES[p]) begin
			set_half_period(PHASES[p].half);
			send_idle_pct = PHASES[p].send_pct;
			recv_stall_pct = PHASES[p].recv_pct;
			// long receiver hold-off so the block backs up onto its input
			if (PHASES[p].hold)
				holds_asked++;
			repeat (PHASES[p].count) begin
				it = draw_tick();
				offer_tick(it, 1'b0, '0);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** three_wire_serial_rtc_master: PASSED **");
		else
			$display("** three_wire_serial_rtc_master: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/tws_pkg.sv
design/tws_core.sv
design/three_wire_serial_rtc_master.sv
tb/three_wire_serial_rtc_master_tb.sv
